// ----- hw/rtl/quad_batcher_texture_slots_defines.svh -----
// assertion macros used by the quad batcher rtl
`ifndef QUAD_BATCHER_TEXTURE_SLOTS_DEFINES_SVH
`define QUAD_BATCHER_TEXTURE_SLOTS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define QB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quad batcher check failed");

// next-cycle implication, checked outside reset
`define QB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quad batcher sequencing check failed");

`endif

// ----- hw/rtl/qbts_pkg.sv -----
// types, constants, microcode rom and arithmetic helpers of the quad batcher
package qbts_pkg;

   // batch limits
   localparam int MAX_BATCH_QUADS = 8192;
   localparam int TEXTURE_SLOTS   = 16;
   localparam int SLOT_IDX_W      = $clog2(TEXTURE_SLOTS);
   localparam int SLOT_CNT_W      = $clog2(TEXTURE_SLOTS + 1);
   localparam int QUAD_CNT_W      = $clog2(MAX_BATCH_QUADS + 1);

   // field widths on the ports
   localparam int COORD_W    = 32;
   localparam int COLOR_W    = 32;
   localparam int TEX_ID_W   = 32;
   localparam int OP_W       = 2;
   localparam int KIND_W     = 2;
   localparam int SLOT_W     = 4;
   localparam int OUT_QUAD_W = 14;
   localparam int OUT_SLOT_W = 5;
   localparam int REQ_DATA_W = 224;
   localparam int RSP_DATA_W = 192;

   // input operations
   localparam logic [OP_W-1:0] OP_BEGIN    = 2'd0;
   localparam logic [OP_W-1:0] OP_END      = 2'd1;
   localparam logic [OP_W-1:0] OP_SOLID    = 2'd2;
   localparam logic [OP_W-1:0] OP_TEXTURED = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BIND   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DRAW   = 2'd2;

   // datapath actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_CLEAR   = 3'd1;
   localparam logic [2:0] ACT_COMPARE = 3'd2;
   localparam logic [2:0] ACT_SELECT  = 3'd3;
   localparam logic [2:0] ACT_BIND    = 3'd4;
   localparam logic [2:0] ACT_INC     = 3'd5;

   // jump conditions
   localparam logic [3:0] C_NEVER       = 4'd0;
   localparam logic [3:0] C_ALWAYS      = 4'd1;
   localparam logic [3:0] C_NO_BEAT     = 4'd2;
   localparam logic [3:0] C_OP_QUAD     = 4'd3;
   localparam logic [3:0] C_OP_END      = 4'd4;
   localparam logic [3:0] C_Q_ZERO      = 4'd5;
   localparam logic [3:0] C_Q_BELOW_MAX = 4'd6;
   localparam logic [3:0] C_OP_SOLID    = 4'd7;
   localparam logic [3:0] C_HIT         = 4'd8;
   localparam logic [3:0] C_SLOTS_FREE  = 4'd9;

   // program addresses
   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] PC_FETCH      = 5'd0;
   localparam logic [PC_W-1:0] PC_DISP_QUAD  = 5'd1;
   localparam logic [PC_W-1:0] PC_DISP_END   = 5'd2;
   localparam logic [PC_W-1:0] PC_BEGIN      = 5'd3;
   localparam logic [PC_W-1:0] PC_END_CHK    = 5'd4;
   localparam logic [PC_W-1:0] PC_END_DRAW   = 5'd5;
   localparam logic [PC_W-1:0] PC_QUAD_CHK   = 5'd6;
   localparam logic [PC_W-1:0] PC_FULL_DRAW  = 5'd7;
   localparam logic [PC_W-1:0] PC_COMPARE    = 5'd8;
   localparam logic [PC_W-1:0] PC_SELECT     = 5'd9;
   localparam logic [PC_W-1:0] PC_SLOT_CHK   = 5'd10;
   localparam logic [PC_W-1:0] PC_EVICT_CHK  = 5'd11;
   localparam logic [PC_W-1:0] PC_EVICT_DRAW = 5'd12;
   localparam logic [PC_W-1:0] PC_EVICT_CLR  = 5'd13;
   localparam logic [PC_W-1:0] PC_BIND       = 5'd14;
   localparam logic [PC_W-1:0] PC_VTX0       = 5'd15;
   localparam logic [PC_W-1:0] PC_VTX1       = 5'd16;
   localparam logic [PC_W-1:0] PC_VTX2       = 5'd17;
   localparam logic [PC_W-1:0] PC_VTX3       = 5'd18;

   // one control word per program step
   typedef struct packed {
      logic              emit;
      logic [KIND_W-1:0] kind;
      logic [1:0]        corner;
      logic              last;
      logic [2:0]        act;
      logic [3:0]        cond;
      logic [PC_W-1:0]   target;
   } ucw_type;

   function automatic ucw_type make_cw(logic emit, logic [KIND_W-1:0] kind,
                                       logic [1:0] corner, logic last, logic [2:0] act,
                                       logic [3:0] cond, logic [PC_W-1:0] target);
      ucw_type cw;
      cw.emit   = emit;
      cw.kind   = kind;
      cw.corner = corner;
      cw.last   = last;
      cw.act    = act;
      cw.cond   = cond;
      cw.target = target;
      return cw;
   endfunction

   // the program: fetch, dispatch, batch closing, slot lookup and bind, four corners
   function automatic ucw_type ucode_rom(logic [PC_W-1:0] pc);
      ucw_type cw;
      case (pc)
         PC_FETCH:      cw = make_cw(1'b0, KIND_VERTEX, 2'd0, 1'b0, ACT_NONE,
                                     C_NO_BEAT, PC_FETCH);
         PC_DISP_QUAD:  cw = make_cw(1'b0, KIND_VERTEX, 2'd0, 1'b0, ACT_NONE,
                                     C_OP_QUAD, PC_QUAD_CHK);
         PC_DISP_END:   cw = make_cw(1'b0, KIND_VERTEX, 2'd0, 1'b0, ACT_NONE,
                                     C_OP_END, PC_END_CHK);
         PC_BEGIN:      cw = make_cw(1'b0, KIND_VERTEX, 2'd0, 1'b0, ACT_CLEAR,
                                     C_ALWAYS, PC_FETCH);
         PC_END_CHK:    cw = make_cw(1'b0, KIND_VERTEX, 2'd0, 1'b0, ACT_NONE,
                                     C_Q_ZERO, PC_FETCH);
         PC_END_DRAW:   cw = make_cw(1'b1, KIND_DRAW, 2'd0, 1'b1, ACT_CLEAR,
                                     C_ALWAYS, PC_FETCH);
         PC_QUAD_CHK:   cw = make_cw(1'b0, KIND_VERTEX, 2'd0, 1'b0, ACT_NONE,
                                     C_Q_BELOW_MAX, PC_COMPARE);
         PC_FULL_DRAW:  cw = make_cw(1'b1, KIND_DRAW, 2'd0, 1'b0, ACT_CLEAR,
                                     C_NEVER, PC_FETCH);
         PC_COMPARE:    cw = make_cw(1'b0, KIND_VERTEX, 2'd0, 1'b0, ACT_COMPARE,
                                     C_OP_SOLID, PC_VTX0);
         PC_SELECT:     cw = make_cw(1'b0, KIND_VERTEX, 2'd0, 1'b0, ACT_SELECT,
                                     C_HIT, PC_VTX0);
         PC_SLOT_CHK:   cw = make_cw(1'b0, KIND_VERTEX, 2'd0, 1'b0, ACT_NONE,
                                     C_SLOTS_FREE, PC_BIND);
         PC_EVICT_CHK:  cw = make_cw(1'b0, KIND_VERTEX, 2'd0, 1'b0, ACT_NONE,
                                     C_Q_ZERO, PC_EVICT_CLR);
         PC_EVICT_DRAW: cw = make_cw(1'b1, KIND_DRAW, 2'd0, 1'b0, ACT_CLEAR,
                                     C_ALWAYS, PC_BIND);
         PC_EVICT_CLR:  cw = make_cw(1'b0, KIND_VERTEX, 2'd0, 1'b0, ACT_CLEAR,
                                     C_NEVER, PC_FETCH);
         PC_BIND:       cw = make_cw(1'b1, KIND_BIND, 2'd0, 1'b0, ACT_BIND,
                                     C_NEVER, PC_FETCH);
         PC_VTX0:       cw = make_cw(1'b1, KIND_VERTEX, 2'd0, 1'b0, ACT_NONE,
                                     C_NEVER, PC_FETCH);
         PC_VTX1:       cw = make_cw(1'b1, KIND_VERTEX, 2'd1, 1'b0, ACT_NONE,
                                     C_NEVER, PC_FETCH);
         PC_VTX2:       cw = make_cw(1'b1, KIND_VERTEX, 2'd2, 1'b0, ACT_NONE,
                                     C_NEVER, PC_FETCH);
         PC_VTX3:       cw = make_cw(1'b1, KIND_VERTEX, 2'd3, 1'b1, ACT_INC,
                                     C_ALWAYS, PC_FETCH);
         default:       cw = make_cw(1'b0, KIND_VERTEX, 2'd0, 1'b0, ACT_NONE,
                                     C_ALWAYS, PC_FETCH);
      endcase
      return cw;
   endfunction

   // signed q16.16 add that clamps to the 32-bit range
   function automatic logic [COORD_W-1:0] sat_add(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
      logic [COORD_W:0] s;
      s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
      if (s[COORD_W] != s[COORD_W-1]) begin
         return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end
      return s[COORD_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/quad_batcher_texture_slots.sv -----
// Sprite quad batcher with texture slot table, run by a microcoded sequencer.
//
// Input channel req_*: one beat per item; req_tuser carries the operation
// (begin, end, solid quad, textured quad), req_tdata the quad fields.
// Result channel rsp_*: vertex, slot-bind and batch-draw beats; rsp_tuser is
// the kind, rsp_tlast marks the final beat of an input item. Begin beats and
// end beats of an empty batch give no result.
// A step counter walks a small program in a rom; each step may drive one
// datapath action and one result beat, and may test a condition and jump.
// An item is taken only in the fetch step, so items are handled one at a time.
// Slot lookup compares all bound table entries at once in one step, registered,
// and a priority pick in the next step.
// The result register lets the sequencer fetch the next item while the last
// beat waits; a stalled receiver holds the sequencer at its next emit step.
// Reset (synchronous, active high) empties the batch and the result register;
// the slot table needs no clearing, since only entries bound in the current
// batch are ever compared.
module quad_batcher_texture_slots import qbts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_x, pos_y, pos_z, size_w, size_h, color_rgba, texture_id
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // vert_x, vert_y, vert_z, tex_u, tex_v, vert_color, slot, bound_texture,
   // batch_quads, batch_slots, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // kind
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);

   `include "quad_batcher_texture_slots_defines.svh"

   // sequencer and batch state
   logic [PC_W-1:0]       pc_ff, pc_in;
   logic [SLOT_CNT_W-1:0] slots_used_ff, slots_used_in;
   logic [QUAD_CNT_W-1:0] quads_ff, quads_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // item and datapath registers
   logic [OP_W-1:0]       op_ff;
   logic [COORD_W-1:0]    pos_x_ff, pos_y_ff, pos_z_ff, size_w_ff, size_h_ff;
   logic [COORD_W-1:0]    x2_ff, y2_ff;
   logic [COLOR_W-1:0]    color_ff;
   logic [TEX_ID_W-1:0]   tex_id_ff;
   logic [TEXTURE_SLOTS-1:0] match_ff;
   logic [SLOT_IDX_W-1:0] slot_ff;
   logic [TEX_ID_W-1:0]   slot_table_ff [TEXTURE_SLOTS];
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [KIND_W-1:0]     rsp_kind_ff;
   logic                  rsp_last_ff;

   ucw_type               cw;
   logic                  out_free;
   logic                  step_go;
   logic                  take;
   logic                  jump;
   logic                  emit_go;
   logic [TEXTURE_SLOTS-1:0] match_vec;
   logic [SLOT_IDX_W-1:0] hit_idx;
   logic                  vtx_u, vtx_v;
   logic [RSP_DATA_W-1:0] rsp_data_new;

   // current control word
   assign cw         = ucode_rom(pc_ff);
   assign req_tready = (pc_ff == PC_FETCH);
   assign take       = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_go    = !cw.emit || out_free;
   assign emit_go    = cw.emit && out_free;

   // jump condition
   always_comb begin
      case (cw.cond)
         C_NEVER:       jump = 1'b0;
         C_ALWAYS:      jump = 1'b1;
         C_NO_BEAT:     jump = !req_tvalid;
         C_OP_QUAD:     jump = op_ff[1];
         C_OP_END:      jump = (op_ff == OP_END);
         C_Q_ZERO:      jump = (quads_ff == '0);
         C_Q_BELOW_MAX: jump = (quads_ff < QUAD_CNT_W'(MAX_BATCH_QUADS));
         C_OP_SOLID:    jump = (op_ff == OP_SOLID);
         C_HIT:         jump = |match_ff;
         C_SLOTS_FREE:  jump = (slots_used_ff < SLOT_CNT_W'(TEXTURE_SLOTS));
         default:       jump = 1'b0;
      endcase
   end

   // step counter
   always_comb begin
      pc_in = pc_ff;
      if (step_go) begin
         pc_in = jump ? cw.target : pc_ff + PC_W'(1);
      end
   end

   // compare the texture id against every slot bound in this batch
   always_comb begin
      match_vec = '0;
      for (int i = 1; i < TEXTURE_SLOTS; i++) begin
         match_vec[i] = (SLOT_CNT_W'(i) < slots_used_ff) && (slot_table_ff[i] == tex_id_ff);
      end
   end

   // lowest matching slot wins
   always_comb begin
      hit_idx = '0;
      for (int i = TEXTURE_SLOTS - 1; i >= 1; i--) begin
         if (match_ff[i]) begin
            hit_idx = SLOT_IDX_W'(i);
         end
      end
   end

   // batch counters
   always_comb begin
      slots_used_in = slots_used_ff;
      quads_in      = quads_ff;
      if (step_go) begin
         case (cw.act)
            ACT_CLEAR: begin
               slots_used_in = SLOT_CNT_W'(1);
               quads_in      = '0;
            end
            ACT_BIND: slots_used_in = slots_used_ff + SLOT_CNT_W'(1);
            ACT_INC:  quads_in      = quads_ff + QUAD_CNT_W'(1);
            default: ;
         endcase
      end
   end

   // result beat contents, unused fields zero
   assign vtx_u = (cw.corner == 2'd1) || (cw.corner == 2'd2);
   assign vtx_v = cw.corner[1];
   always_comb begin
      rsp_data_new = '0;
      case (cw.kind)
         KIND_VERTEX: begin
            rsp_data_new[31:0]    = vtx_u ? x2_ff : pos_x_ff;
            rsp_data_new[63:32]   = vtx_v ? y2_ff : pos_y_ff;
            rsp_data_new[95:64]   = pos_z_ff;
            rsp_data_new[96]      = vtx_u;
            rsp_data_new[97]      = vtx_v;
            rsp_data_new[129:98]  = color_ff;
            rsp_data_new[133:130] = SLOT_W'(slot_ff);
         end
         KIND_BIND: begin
            rsp_data_new[133:130] = SLOT_W'(slots_used_ff);
            rsp_data_new[165:134] = tex_id_ff;
         end
         KIND_DRAW: begin
            rsp_data_new[179:166] = OUT_QUAD_W'(quads_ff);
            rsp_data_new[184:180] = OUT_SLOT_W'(slots_used_ff);
         end
         default: ;
      endcase
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= PC_FETCH;
         slots_used_ff <= SLOT_CNT_W'(1);
         quads_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         slots_used_ff <= slots_used_in;
         quads_ff      <= quads_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // item capture and datapath registers
   always_ff @(posedge clock) begin
      if (take) begin
         op_ff     <= req_tuser;
         pos_x_ff  <= req_tdata[31:0];
         pos_y_ff  <= req_tdata[63:32];
         pos_z_ff  <= req_tdata[95:64];
         size_w_ff <= req_tdata[127:96];
         size_h_ff <= req_tdata[159:128];
         color_ff  <= req_tdata[191:160];
         tex_id_ff <= req_tdata[223:192];
      end
      x2_ff <= sat_add(pos_x_ff, size_w_ff);
      y2_ff <= sat_add(pos_y_ff, size_h_ff);
      if (step_go) begin
         case (cw.act)
            ACT_COMPARE: begin
               match_ff <= match_vec;
               slot_ff  <= '0;
            end
            ACT_SELECT: slot_ff <= hit_idx;
            ACT_BIND: begin
               slot_ff <= slots_used_ff[SLOT_IDX_W-1:0];
               slot_table_ff[slots_used_ff[SLOT_IDX_W-1:0]] <= tex_id_ff;
            end
            default: ;
         endcase
      end
      if (emit_go) begin
         rsp_data_ff <= rsp_data_new;
         rsp_kind_ff <= cw.kind;
         rsp_last_ff <= cw.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks on the batch state and the sequencer
   `QB_ASSERT_NOW(a_slots_range, clock, reset, 1'b1,
      (slots_used_ff >= SLOT_CNT_W'(1)) && (slots_used_ff <= SLOT_CNT_W'(TEXTURE_SLOTS)))
   `QB_ASSERT_NOW(a_quads_range, clock, reset, 1'b1,
      quads_ff <= QUAD_CNT_W'(MAX_BATCH_QUADS))
   `QB_ASSERT_NOW(a_bind_has_room, clock, reset, emit_go && (cw.kind == KIND_BIND),
      slots_used_ff < SLOT_CNT_W'(TEXTURE_SLOTS))
   `QB_ASSERT_NOW(a_draw_not_empty, clock, reset, emit_go && (cw.kind == KIND_DRAW),
      quads_ff != '0)
   `QB_ASSERT_NEXT(a_last_to_fetch, clock, reset, emit_go && cw.last,
      (pc_ff == PC_FETCH) && rsp_tvalid)

endmodule
